// ===== rtl/pft_pkg.sv =====
// Shared types, constants and helpers of the port forwarding table.
`default_nettype none

package pft_pkg;

  // Number of forwarding entries held by the table.
  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int KEY_W   = 16;
  localparam int ADDR_W  = 32;
  localparam int DPORT_W = 16;
  localparam int OUT_IDX_W = 4;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4,
    ST_INVALID  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_t;

  // Write command from the sequencer to the entry store.
  typedef struct packed {
    logic               valid_set;
    logic               valid_clr;
    logic               key_we;
    logic               dest_we;
    idx_t               idx;
    logic [KEY_W-1:0]   key;
    logic [ADDR_W-1:0]  dest_addr;
    logic [DPORT_W-1:0] fwd_port;
  } wr_cmd_t;

  // Low bits of an entry index as reported on the result port.
  function automatic logic [OUT_IDX_W-1:0] idx_to_out(input idx_t idx);
    logic [IDX_W+OUT_IDX_W-1:0] wide;
    wide = {{OUT_IDX_W{1'b0}}, idx};
    return wide[OUT_IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/port_forward_table.sv =====
// Top level of the port forwarding table: sequencer plus entry store.
`default_nettype none

// A request is taken at a rising edge where start is high and busy is low.
// Every request yields exactly one result, shown for one cycle with done
// high; the receiver cannot stall it. A malformed request (port zero, or
// destination port zero on an add) goes straight to the commit state with no
// scan. Any other request reads all ENTRIES keys one per cycle from the key
// memory through its single read port, then passes through a drain state for
// the last compare and a commit state; done is registered from the commit
// state. busy falls in the cycle that done rises, so a new request can be
// taken while the result is shown.
// Valid flags are flip-flops that reset clears at once; no clearing pass.

module port_forward_table
  import pft_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               mode,
  input  wire logic [KEY_W-1:0]   port,
  input  wire logic [ADDR_W-1:0]  dest_ip,
  input  wire logic [DPORT_W-1:0] fwd_port,
  output logic                    done,
  output logic [2:0]              status,
  output logic [OUT_IDX_W-1:0]    entry_index,
  output logic                    table_changed
);

  // Read port of the store: address issued by the scan, data registered and returned in the next cycle.
  idx_t             rd_addr;
  logic [KEY_W-1:0] rd_key;
  logic             rd_valid;

  // Table write from the commit cycle. Writes happen only while busy, and a
  // new scan starts only after the commit, so reads never overlap a write.
  wr_cmd_t wr;

  pft_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .port          (port),
    .dest_ip       (dest_ip),
    .fwd_port      (fwd_port),
    .done          (done),
    .status        (status),
    .entry_index   (entry_index),
    .table_changed (table_changed),
    .rd_addr       (rd_addr),
    .rd_key        (rd_key),
    .rd_valid      (rd_valid),
    .wr            (wr)
  );

  pft_entry_store u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (rd_addr),
    .rd_key   (rd_key),
    .rd_valid (rd_valid),
    .wr       (wr)
  );

endmodule

`default_nettype wire

// ===== rtl/pft_entry_store.sv =====
// Entry store: valid flags, key memory and destination memory.
`default_nettype none

module pft_entry_store
  import pft_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire idx_t             rd_addr,
  output logic [KEY_W-1:0]      rd_key,
  output logic                  rd_valid,
  input  wire wr_cmd_t          wr
);

  logic [ENTRIES-1:0] valid;
  logic [KEY_W-1:0]   key_mem  [ENTRIES];
  logic [ADDR_W+DPORT_W-1:0] dest_mem [ENTRIES];

  // Valid flags live in flip-flops so that reset empties the table at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.valid_set) begin
      valid[wr.idx] <= 1'b1;
    end else if (wr.valid_clr) begin
      valid[wr.idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.key_we) begin
      key_mem[wr.idx] <= wr.key;
    end
    rd_key   <= key_mem[rd_addr];
    rd_valid <= valid[rd_addr];
  end

  // Destination of each entry, the payload a lookup path would return.
  always_ff @(posedge clk) begin
    if (wr.dest_we) begin
      dest_mem[wr.idx] <= {wr.dest_addr, wr.fwd_port};
    end
  end

`ifndef ASSERT_OFF
  a_one_valid_op: assert property (@(posedge clk) disable iff (rst)
    !(wr.valid_set && wr.valid_clr))
    else $error("valid flag set and cleared in one cycle");
  a_insert_writes_all: assert property (@(posedge clk) disable iff (rst)
    wr.valid_set |-> (wr.key_we && wr.dest_we))
    else $error("insert without key and destination write");
  a_clear_no_write: assert property (@(posedge clk) disable iff (rst)
    wr.valid_clr |-> (!wr.key_we && !wr.dest_we))
    else $error("remove also wrote entry contents");
`endif

endmodule

`default_nettype wire

// ===== rtl/pft_seq.sv =====
// Request sequencer: scans the entry store and commits at most one change per request.
`default_nettype none

module pft_seq
  import pft_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               mode,
  input  wire logic [KEY_W-1:0]   port,
  input  wire logic [ADDR_W-1:0]  dest_ip,
  input  wire logic [DPORT_W-1:0] fwd_port,
  output logic                    done,
  output logic [2:0]              status,
  output logic [OUT_IDX_W-1:0]    entry_index,
  output logic                    table_changed,
  output idx_t                    rd_addr,
  input  wire logic [KEY_W-1:0]   rd_key,
  input  wire logic               rd_valid,
  output wr_cmd_t                 wr
);

  state_t state, state_next;
  idx_t   scan_idx;
  logic   cmp_en;
  idx_t   cmp_idx;
  logic   hit, free;
  idx_t   hit_idx, free_idx;
  logic   req_remove, req_invalid;
  logic [KEY_W-1:0]   req_port;
  logic [ADDR_W-1:0]  req_addr;
  logic [DPORT_W-1:0] req_dport;

  logic    accept;
  logic    scan_last;
  logic    is_match, is_free;
  status_t res_status;
  idx_t    res_idx;
  logic    res_changed;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign scan_last = (scan_idx == idx_t'(ENTRIES - 1));
  assign rd_addr   = scan_idx;
  assign is_match  = cmp_en && rd_valid && (rd_key == req_port);
  assign is_free   = cmp_en && !rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    res_status  = ST_INVALID;
    res_idx     = '0;
    res_changed = 1'b0;
    wr          = '0;
    wr.key       = req_port;
    wr.dest_addr = req_addr;
    wr.fwd_port  = req_dport;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if ((port == '0) || (!mode && (fwd_port == '0))) begin
            state_next = S_COMMIT;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        state_next = S_IDLE;
        if (req_invalid) begin
          res_status = ST_INVALID;
        end else if (req_remove) begin
          if (hit) begin
            res_status   = ST_REMOVED;
            res_idx      = hit_idx;
            res_changed  = 1'b1;
            wr.valid_clr = 1'b1;
            wr.idx       = hit_idx;
          end else begin
            res_status = ST_NOTFOUND;
          end
        end else if (hit) begin
          res_status  = ST_UPDATED;
          res_idx     = hit_idx;
          res_changed = 1'b1;
          wr.dest_we  = 1'b1;
          wr.idx      = hit_idx;
        end else if (free) begin
          res_status   = ST_INSERTED;
          res_idx      = free_idx;
          res_changed  = 1'b1;
          wr.valid_set = 1'b1;
          wr.key_we    = 1'b1;
          wr.dest_we   = 1'b1;
          wr.idx       = free_idx;
        end else begin
          res_status = ST_FULL;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Scan control and first-match / first-free tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      cmp_en   <= 1'b0;
      hit      <= 1'b0;
      free     <= 1'b0;
      done     <= 1'b0;
    end else begin
      cmp_en <= (state == S_SCAN);
      done   <= (state == S_COMMIT);
      if (accept) begin
        scan_idx <= '0;
        hit      <= 1'b0;
        free     <= 1'b0;
      end else begin
        if ((state == S_SCAN) && !scan_last) begin
          scan_idx <= scan_idx + idx_t'(1);
        end
        if (is_match && !hit) begin
          hit <= 1'b1;
        end
        if (is_free && !free) begin
          free <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx;
    if (is_match && !hit) begin
      hit_idx <= cmp_idx;
    end
    if (is_free && !free) begin
      free_idx <= cmp_idx;
    end
    if (accept) begin
      req_remove  <= mode;
      req_invalid <= (port == '0) || (!mode && (fwd_port == '0));
      req_port    <= port;
      req_addr    <= dest_ip;
      req_dport   <= fwd_port;
    end
    if (state == S_COMMIT) begin
      status        <= res_status;
      entry_index   <= idx_to_out(res_idx);
      table_changed <= res_changed;
    end
  end

`ifndef ASSERT_OFF
  a_done_after_commit: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_COMMIT))
    else $error("result strobe without a commit cycle");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("accepted request did not start");
  a_commit_scan_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT) |-> !cmp_en)
    else $error("commit while a compare is still pending");
  a_write_only_commit: assert property (@(posedge clk) disable iff (rst)
    (wr.key_we || wr.dest_we || wr.valid_clr) |-> (state == S_COMMIT))
    else $error("table write outside the commit cycle");
`endif

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the port forwarding table: predictor, driver and monitor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pft_pkg::*;

  // Request modes as carried on the mode port.
  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // Number of keys that random traffic draws from. It is a little larger than
  // the table, so adds both hit live entries and run into a full table.
  localparam int KEY_POOL = 20;

  // Items per random phase, and the length of the quiet tail at the end.
  localparam int PHASE_ITEMS = 185;
  localparam int TAIL_CYCLES = 40;

  typedef struct {
    logic               mode;
    logic [KEY_W-1:0]   port;
    logic [ADDR_W-1:0]  ip;
    logic [DPORT_W-1:0] dport;
  } fwd_request_t;

  typedef struct {
    status_t              status;
    logic [OUT_IDX_W-1:0] index;
    logic                 changed;
  } fwd_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Every input of the block starts at a known value.
  logic               start     = 1'b0;
  logic               mode      = MODE_ADD;
  logic [KEY_W-1:0]   port      = '0;
  logic [ADDR_W-1:0]  dest_ip   = '0;
  logic [DPORT_W-1:0] fwd_port  = '0;

  logic                 busy;
  logic                 done;
  logic [2:0]           status;
  logic [OUT_IDX_W-1:0] entry_index;
  logic                 table_changed;

  port_forward_table u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .port         (port),
    .dest_ip      (dest_ip),
    .fwd_port     (fwd_port),
    .done         (done),
    .status       (status),
    .entry_index  (entry_index),
    .table_changed(table_changed)
  );

  // Period of 4 ns: rising edges at 2, 6, 10 and so on.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Reset is held high from time zero and dropped on a falling edge.
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // The timeout is far beyond the slowest correct run, which needs about
  // 800 requests plus the sender gaps.
  initial begin
    #2_000_000ns;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Forwarding table predictor.
  // ---------------------------------------------------------------------

  // Shadow copy of the table. Keys and destinations are only ever looked at
  // behind a set valid mark, so their reset contents do not matter.
  logic               fwd_valid [ENTRIES];
  logic [KEY_W-1:0]   fwd_key   [ENTRIES];
  logic [ADDR_W-1:0]  fwd_addr  [ENTRIES];
  logic [DPORT_W-1:0] fwd_dport [ENTRIES];

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      fwd_valid[i] = 1'b0;
      fwd_key[i]   = '0;
      fwd_addr[i]  = '0;
      fwd_dport[i] = '0;
    end
  end

  // Applies one request to the shadow table and returns the result the block
  // must produce for it. Matches and free slots go to the lowest index.
  function automatic fwd_reply_t apply_request(fwd_request_t rq);
    fwd_reply_t rp;
    int         hit;
    int         free;
    int         slot;
    rp.status  = ST_INVALID;
    rp.index   = '0;
    rp.changed = 1'b0;
    hit  = -1;
    free = -1;
    slot = -1;
    // A zero key is never legal, and an add needs a nonzero destination port.
    // A remove ignores both destination fields.
    if (rq.port == '0 || (rq.mode == MODE_ADD && rq.dport == '0)) begin
      return rp;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && fwd_valid[i] && fwd_key[i] == rq.port) begin
        hit = i;
      end
      if (free < 0 && !fwd_valid[i]) begin
        free = i;
      end
    end
    if (rq.mode == MODE_REMOVE) begin
      if (hit < 0) begin
        rp.status = ST_NOTFOUND;
      end else begin
        fwd_valid[hit] = 1'b0;
        rp.status = ST_REMOVED;
        slot = hit;
      end
    end else if (hit >= 0) begin
      // Rewriting the same destination still counts as a change.
      fwd_addr[hit]  = rq.ip;
      fwd_dport[hit] = rq.dport;
      rp.status = ST_UPDATED;
      slot = hit;
    end else if (free < 0) begin
      rp.status = ST_FULL;
    end else begin
      fwd_valid[free] = 1'b1;
      fwd_key[free]   = rq.port;
      fwd_addr[free]  = rq.ip;
      fwd_dport[free] = rq.dport;
      rp.status = ST_INSERTED;
      slot = free;
    end
    if (slot >= 0) begin
      // Only the low bits of the slot number reach the result port.
      rp.index   = OUT_IDX_W'(slot);
      rp.changed = 1'b1;
    end
    return rp;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: presents queued requests, changing inputs on falling edges.
  // ---------------------------------------------------------------------

  fwd_request_t pending_requests[$];
  int           requests_queued = 0;
  int           gap_pct = 0;
  logic         beat_taken = 1'b0;

  // A new request may only be put up once the previous one has been taken,
  // which the monitor records at the rising edge. Each step assigns start at
  // most once, so a back-to-back stream keeps start high throughout.
  always @(negedge clk) begin
    fwd_request_t rq;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || beat_taken) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= gap_pct) begin
        rq = pending_requests.pop_front();
        start     <= 1'b1;
        mode      <= rq.mode;
        port      <= rq.port;
        dest_ip   <= rq.ip;
        fwd_port  <= rq.dport;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: takes beats on rising edges and checks every result.
  // ---------------------------------------------------------------------

  fwd_reply_t expected_replies[$];
  int         replies_seen = 0;
  int         mismatches   = 0;

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  // Everything here is read before the block's own updates at this edge land,
  // so done and the result fields belong to the cycle that just ended.
  always @(posedge clk) begin
    fwd_reply_t   want;
    fwd_request_t rq;
    beat_taken <= !rst && start && !busy;
    if (!rst) begin
      // A result is checked before the beat taken at this same edge is
      // predicted; a new request is never answered at the edge that takes it.
      if (done) begin
        replies_seen <= replies_seen + 1;
        if (expected_replies.size() == 0) begin
          report_mismatch($sformatf("unexpected result: status %0d index %0d changed %0b",
                                    status, entry_index, table_changed));
        end else begin
          want = expected_replies.pop_front();
          if (status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
          end
          if (entry_index !== want.index) begin
            report_mismatch($sformatf("entry_index %0d, expected %0d",
                                      entry_index, want.index));
          end
          if (table_changed !== want.changed) begin
            report_mismatch($sformatf("table_changed %0b, expected %0b",
                                      table_changed, want.changed));
          end
        end
      end
      if (start && !busy) begin
        rq.mode  = mode;
        rq.port  = port;
        rq.ip    = dest_ip;
        rq.dport = fwd_port;
        expected_replies.push_back(apply_request(rq));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------

  logic [KEY_W-1:0] key_pool [KEY_POOL];

  task automatic queue_request(input logic m, input logic [KEY_W-1:0] p,
                               input logic [ADDR_W-1:0] ip, input logic [DPORT_W-1:0] dp);
    fwd_request_t rq;
    rq.mode  = m;
    rq.port  = p;
    rq.ip    = ip;
    rq.dport = dp;
    pending_requests.push_back(rq);
    requests_queued++;
  endtask

  // The sender holds off until every queued request has been answered; the
  // result count only moves on rising edges, so it is polled on falling ones.
  task automatic wait_for_drain();
    @(negedge clk);
    while (replies_seen != requests_queued) begin
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  // One random request. Most traffic uses keys from the pool with an add or
  // remove mix set by add_pct; the rest are stray keys and malformed requests.
  task automatic queue_random_request(input int add_pct);
    int                 roll;
    logic               m;
    logic [KEY_W-1:0]   p;
    logic [ADDR_W-1:0]  ip;
    logic [DPORT_W-1:0] dp;
    roll = $urandom_range(99);
    m    = ($urandom_range(99) < add_pct) ? MODE_ADD : MODE_REMOVE;
    p    = key_pool[$urandom_range(KEY_POOL - 1)];
    ip   = $urandom;
    dp   = DPORT_W'($urandom_range(65535, 1));
    if (roll < 3) begin
      // Zero key, in either mode.
      p = '0;
    end else if (roll < 6) begin
      // Add with a zero destination port is rejected outright.
      m  = MODE_ADD;
      dp = '0;
    end else if (roll < 11) begin
      // Stray key: almost always a miss.
      p = KEY_W'($urandom_range(65535, 1));
    end
    if (roll >= 90) begin
      // Destination extremes.
      ip = $urandom_range(1) ? '1 : '0;
      dp = $urandom_range(1) ? '1 : DPORT_W'(1);
    end
    if (m == MODE_REMOVE && $urandom_range(3) == 0) begin
      // A remove ignores its destination fields, zero included.
      dp = DPORT_W'($urandom_range(65535));
    end
    queue_request(m, p, ip, dp);
  endtask

  initial begin
    int gap_by_phase [4];
    int add_by_phase [4];
    gap_by_phase = '{0, 63, 9, 0};
    add_by_phase = '{70, 60, 35, 65};

    // Directed part: malformed requests, a miss on an empty table, extreme
    // field values, updates with new and with identical values, a full table
    // and reuse of the lowest free slot.
    queue_request(MODE_ADD, '0, 32'h1234_5678, 16'h0050);
    queue_request(MODE_REMOVE, '0, '0, '0);
    queue_request(MODE_ADD, 16'h0007, 32'h0A00_0001, '0);
    queue_request(MODE_REMOVE, 16'h0007, '1, '0);
    queue_request(MODE_ADD, '1, '1, '1);
    queue_request(MODE_ADD, 16'h0001, '0, 16'h0001);
    queue_request(MODE_ADD, '1, '1, '1);
    queue_request(MODE_ADD, 16'h0001, 32'h5555_AAAA, 16'hAAAA);
    queue_request(MODE_REMOVE, 16'h0001, 32'hDEAD_0000, '0);
    for (int k = 2; k <= 16; k++) begin
      queue_request(MODE_ADD, KEY_W'(k), $urandom, DPORT_W'($urandom_range(65535, 1)));
    end
    // The table now holds sixteen keys, so a new one finds no room.
    queue_request(MODE_ADD, 16'h8000, 32'hC0A8_0001, 16'h1F90);
    queue_request(MODE_REMOVE, '1, '0, '0);
    queue_request(MODE_ADD, 16'h8000, 32'hC0A8_0001, 16'h1F90);
    wait_for_drain();

    // Random phases with sender gaps and add/remove mixes that vary by phase.
    // Each phase ends with the sender held off until all results are back.
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = gap_by_phase[ph];
      for (int k = 0; k < KEY_POOL; k++) begin
        key_pool[k] = KEY_W'($urandom_range(65535, 1));
      end
      if (ph == 1) begin
        key_pool[0] = '1;
        key_pool[1] = KEY_W'(1);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        queue_random_request(add_by_phase[ph]);
      end
      wait_for_drain();
    end

    // Quiet tail: any late or extra result would show up here.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
